// ===== rtl/core/lscm_pkg.sv =====
// Shared types and constants for the light sensor calibration monitor.
`timescale 1ns / 1ps
`default_nettype none

package lscm_pkg;

    // Default sample width in bits
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths
    localparam int TIME_W     = 32;
    localparam int DZ_W       = 12;
    localparam int IV_W       = 16;
    localparam int FS_W       = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int MODE_W     = 4;
    localparam int LEVEL_W    = 8;
    localparam int QUOT_W     = LEVEL_W;
    localparam int OUT_BITS   = MODE_W + LEVEL_W + 1;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    // Register reset values
    localparam logic [DZ_W-1:0] DZ_RESET = DZ_W'(30);
    localparam logic [IV_W-1:0] IV_RESET = IV_W'(30);
    localparam logic [FS_W-1:0] FS_RESET = FS_W'(3300);

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DEADZONE  = 2'd0,
        CFG_INTERVAL  = 2'd1,
        CFG_FULLSCALE = 2'd2
    } cfg_idx_t;

    // Monitor modes
    typedef enum logic [MODE_W-1:0] {
        MODE_UNCAL      = 4'd0,
        MODE_NEED_MIN   = 4'd1,
        MODE_NEED_MAX   = 4'd2,
        MODE_SUCCESS    = 4'd3,
        MODE_REGULAR    = 4'd4,
        MODE_ABOVE      = 4'd5,
        MODE_BELOW      = 4'd6,
        MODE_UNKNOWN    = 4'd7,
        MODE_RESET_DONE = 4'd8,
        MODE_FORCE      = 4'd9
    } mode_t;

    // Item sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_EVAL,
        SEQ_DIV,
        SEQ_EMIT
    } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/lscm_div.sv =====
// Shared restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module lscm_div #(
    parameter int DEN_W = lscm_pkg::SAMPLE_BITS_DEF,
    parameter int Q_W   = lscm_pkg::QUOT_W
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DEN_W+Q_W-1:0] num,
    input  wire logic [DEN_W-1:0]     den,
    output logic                      done,
    output logic [Q_W-1:0]            quot
);

    localparam int NUM_W = DEN_W + Q_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             fits;

    // Trial subtract of the shifted divisor
    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = NUM_W'(den) << (Q_W - 1);
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quot_next = {quot_reg[Q_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(Q_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/core/light_sensor_calibration_monitor.sv =====
// Light sensor calibration monitor: top level with mode sequencer and level datapath.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata, each holding one sample,
//   a millisecond timestamp and the short-press, long-press and pattern-done
//   events. Every item produces exactly one result item on m_tvalid/m_tready/
//   m_tdata carrying the mode, the brightness level and an update flag.
//   Configuration registers are written through cfg_we/cfg_addr/cfg_wdata
//   while the block is idle; writes take effect at the next clock edge.
//   Sequence: an item is taken in the idle state, evaluated in the eval
//   state and emitted from the emit state into the output register. When
//   the range mapping runs, the shared divider state lies between eval and
//   emit, with one quotient bit per cycle for the 8-bit level.
//   s_tready is high only while the sequencer is idle, so a new item is
//   taken only after the last one has left the emit state.
//   A finished result waits in the output register; the next item is still
//   accepted and evaluated, and only its emit step waits for m_tready.
//   Reset puts the mode back to uncalibrated, clears the limits, trackers,
//   timer and level to zero and loads the default register values.
`timescale 1ns / 1ps
`default_nettype none

module light_sensor_calibration_monitor #(
    parameter int SAMPLE_BITS = lscm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    // s_tdata: sample_mv, now_ms, button_pressed, button_latched, pattern_done
    input  wire logic                                        s_tvalid,
    output logic                                             s_tready,
    input  wire logic [((SAMPLE_BITS+lscm_pkg::TIME_W+3+7)/8)*8-1:0] s_tdata,
    // m_tdata: mode, brightness_level, level_updated
    output logic                                             m_tvalid,
    input  wire logic                                        m_tready,
    output logic [lscm_pkg::OUT_W-1:0]                       m_tdata,
    input  wire logic                                        cfg_we,
    input  wire logic [lscm_pkg::CFG_ADDR_W-1:0]             cfg_addr,
    input  wire logic [lscm_pkg::CFG_DATA_W-1:0]             cfg_wdata
);

    import lscm_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int CW    = (SB > DZ_W) ? SB : DZ_W;
    localparam int NUM_W = SB + QUOT_W;

    // Configuration registers
    logic [DZ_W-1:0] deadzone_reg;
    logic [IV_W-1:0] interval_reg;
    logic [FS_W-1:0] fullscale_reg;

    // Sequencer
    seq_state_t state_reg, state_next;
    logic       div_start;
    logic       out_load;

    // Captured item
    logic [SB-1:0]     in_sample_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              in_pressed_reg;
    logic              in_latched_reg;
    logic              in_done_reg;

    // Monitor state
    mode_t              mode_reg;
    logic [SB-1:0]      low_reg, high_reg, lowest_reg, highest_reg, last_chg_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               updated_reg;
    logic               smooth_reg;

    // Evaluation results
    mode_t             mode_next;
    logic [SB-1:0]     low_next, high_next, lowest_next, highest_next, last_chg_next;
    logic [TIME_W-1:0] last_time_next;
    logic              updated_next;
    logic              smooth_next;
    logic              need_div;
    logic              zero_level;

    // Mapping operands and divider
    logic [SB-1:0]      clamp_val;
    logic [SB-1:0]      offset;
    logic [NUM_W-1:0]   div_num;
    logic [SB-1:0]      div_den;
    logic               div_done;
    logic [QUOT_W-1:0]  div_quot;
    logic [LEVEL_W+1:0] smooth_sum;

    // Output register
    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg  <= DZ_RESET;
            interval_reg  <= IV_RESET;
            fullscale_reg <= FS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DEADZONE:  deadzone_reg  <= cfg_wdata[DZ_W-1:0];
                CFG_INTERVAL:  interval_reg  <= cfg_wdata[IV_W-1:0];
                CFG_FULLSCALE: fullscale_reg <= cfg_wdata[FS_W-1:0];
                default:       ;
            endcase
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE: if (s_tvalid) state_next = SEQ_EVAL;
            SEQ_EVAL: state_next = need_div ? SEQ_DIV : SEQ_EMIT;
            SEQ_DIV:  if (div_done) state_next = SEQ_EMIT;
            SEQ_EMIT: if (!m_tvalid_reg || m_tready) state_next = SEQ_IDLE;
            default:  state_next = SEQ_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready  = (state_reg == SEQ_IDLE);
        div_start = (state_reg == SEQ_EVAL) && need_div;
        out_load  = (state_reg == SEQ_EMIT) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the item fields
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_sample_reg  <= s_tdata[SB-1:0];
            in_now_reg     <= s_tdata[SB+TIME_W-1:SB];
            in_pressed_reg <= s_tdata[SB+TIME_W];
            in_latched_reg <= s_tdata[SB+TIME_W+1];
            in_done_reg    <= s_tdata[SB+TIME_W+2];
        end
    end

    // Evaluate the mode step for the captured item
    always_comb
    begin
        logic          lim_ok;
        logic [SB-1:0] diff;
        mode_t         mode_cur;

        lim_ok   = (high_reg > low_reg);
        mode_cur = (CW'(in_sample_reg) > CW'(fullscale_reg)) ? MODE_UNKNOWN : mode_reg;
        diff     = (in_sample_reg >= last_chg_reg) ? in_sample_reg - last_chg_reg
                                                   : last_chg_reg - in_sample_reg;

        mode_next      = mode_cur;
        low_next       = low_reg;
        high_next      = high_reg;
        lowest_next    = lowest_reg;
        highest_next   = highest_reg;
        last_chg_next  = last_chg_reg;
        last_time_next = last_time_reg;
        updated_next   = 1'b0;
        smooth_next    = 1'b0;
        need_div       = 1'b0;
        zero_level     = 1'b0;

        case (mode_cur)
            MODE_UNCAL:
            begin
                if (in_pressed_reg) mode_next = MODE_NEED_MIN;
            end
            MODE_NEED_MIN:
            begin
                if (in_pressed_reg)
                begin
                    low_next  = in_sample_reg;
                    mode_next = MODE_NEED_MAX;
                end
            end
            MODE_NEED_MAX:
            begin
                if (in_pressed_reg)
                begin
                    high_next = in_sample_reg;
                    mode_next = (low_reg >= in_sample_reg) ? MODE_UNKNOWN : MODE_SUCCESS;
                end
            end
            MODE_SUCCESS:
            begin
                if (in_done_reg)
                begin
                    updated_next = 1'b1;
                    need_div     = lim_ok;
                    zero_level   = !lim_ok;
                    mode_next    = MODE_REGULAR;
                end
                if (in_latched_reg) mode_next = MODE_FORCE;
            end
            MODE_REGULAR:
            begin
                if (!lim_ok)
                begin
                    mode_next = MODE_UNKNOWN;
                end
                else if (in_sample_reg < low_reg)
                begin
                    lowest_next = in_sample_reg;
                    mode_next   = MODE_BELOW;
                end
                else if (in_sample_reg > high_reg)
                begin
                    highest_next = in_sample_reg;
                    mode_next    = MODE_ABOVE;
                end
                if (in_latched_reg) mode_next = MODE_FORCE;
                // Smoothed update, gated by deadzone and interval
                if (!lim_ok)
                begin
                    mode_next = MODE_UNKNOWN;
                end
                else if (CW'(diff) >= CW'(deadzone_reg))
                begin
                    last_chg_next = in_sample_reg;
                    if ((in_now_reg - last_time_reg) >= TIME_W'(interval_reg))
                    begin
                        last_time_next = in_now_reg;
                        updated_next   = 1'b1;
                        smooth_next    = 1'b1;
                        need_div       = 1'b1;
                    end
                end
            end
            MODE_ABOVE:
            begin
                if (highest_reg < in_sample_reg) highest_next = in_sample_reg;
                if (in_latched_reg)
                begin
                    high_next    = highest_next;
                    highest_next = '0;
                    mode_next    = MODE_RESET_DONE;
                end
            end
            MODE_BELOW:
            begin
                if (lowest_reg > in_sample_reg) lowest_next = in_sample_reg;
                if (in_latched_reg)
                begin
                    low_next    = lowest_next;
                    lowest_next = '0;
                    mode_next   = MODE_RESET_DONE;
                end
            end
            MODE_UNKNOWN:
            begin
                if (in_latched_reg) mode_next = MODE_FORCE;
            end
            MODE_RESET_DONE:
            begin
                if (low_reg > high_reg) mode_next = MODE_FORCE;
                if (in_done_reg) mode_next = MODE_SUCCESS;
            end
            MODE_FORCE:
            begin
                if (in_done_reg)
                begin
                    low_next  = '0;
                    high_next = '0;
                    mode_next = MODE_UNCAL;
                end
            end
            default: ;
        endcase
    end

    // Clamp the sample and scale the offset by 255 with a shift and subtract
    assign clamp_val = (in_sample_reg < low_reg)  ? low_reg :
                       (in_sample_reg > high_reg) ? high_reg : in_sample_reg;
    assign offset    = clamp_val - low_reg;
    assign div_num   = (NUM_W'(offset) << LEVEL_W) - NUM_W'(offset);
    assign div_den   = high_reg - low_reg;

    lscm_div #(
        .DEN_W (SB),
        .Q_W   (QUOT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Blend three parts old level with one part new
    assign smooth_sum = {1'b0, level_reg, 1'b0} + (LEVEL_W+2)'(level_reg)
                      + (LEVEL_W+2)'(div_quot);

    // Commit the monitor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_UNCAL;
            low_reg       <= '0;
            high_reg      <= '0;
            lowest_reg    <= '0;
            highest_reg   <= '0;
            last_chg_reg  <= '0;
            last_time_reg <= '0;
            level_reg     <= '0;
            updated_reg   <= 1'b0;
            smooth_reg    <= 1'b0;
        end
        else if (state_reg == SEQ_EVAL)
        begin
            mode_reg      <= mode_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            lowest_reg    <= lowest_next;
            highest_reg   <= highest_next;
            last_chg_reg  <= last_chg_next;
            last_time_reg <= last_time_next;
            updated_reg   <= updated_next;
            smooth_reg    <= smooth_next;
            if (zero_level) level_reg <= '0;
        end
        else if ((state_reg == SEQ_DIV) && div_done)
        begin
            level_reg <= smooth_reg ? smooth_sum[LEVEL_W+1:2] : div_quot;
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= OUT_W'({updated_reg, level_reg, mode_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == SEQ_DIV))
        else $error("divider finished outside the divide state");

    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == SEQ_EVAL))
        else $error("accepted item not evaluated next cycle");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == SEQ_EMIT))
        else $error("result shown without an emit step");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> !s_tready)
        else $error("ready while the divider runs");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench: random and directed items checked against a mode and level predictor.
`timescale 1ns / 1ps

module tb;

    import lscm_pkg::*;

    localparam int S_BITS = SAMPLE_BITS_DEF;
    localparam int S_W    = ((S_BITS + TIME_W + 3 + 7) / 8) * 8;

    // One sensor item as the sender sees it
    typedef struct {
        logic [S_BITS-1:0] sample_mv;
        logic [TIME_W-1:0] stamp_ms;
        logic              pressed;
        logic              latched;
        logic              done;
    } sensor_item_t;

    // One status item as the block returns it
    typedef struct {
        mode_t              mode;
        logic [LEVEL_W-1:0] level;
        logic               updated;
    } status_t;

    // Predict mode and brightness for each accepted item and check the results
    class calib_scoreboard;
        logic [DZ_W-1:0]    deadzone;
        logic [IV_W-1:0]    interval;
        logic [FS_W-1:0]    full_scale;
        mode_t              mode;
        logic [S_BITS-1:0]  low_lim;
        logic [S_BITS-1:0]  high_lim;
        logic [S_BITS-1:0]  lowest;
        logic [S_BITS-1:0]  highest;
        logic [S_BITS-1:0]  last_chg;
        logic [TIME_W-1:0]  last_upd;
        logic [LEVEL_W-1:0] level;
        status_t            status_q[$];
        int                 errors;

        function new();
            deadzone   = DZ_RESET;
            interval   = IV_RESET;
            full_scale = FS_RESET;
            mode       = MODE_UNCAL;
            low_lim    = '0;
            high_lim   = '0;
            lowest     = '0;
            highest    = '0;
            last_chg   = '0;
            last_upd   = '0;
            level      = '0;
            errors     = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DEADZONE:  deadzone   = val[DZ_W-1:0];
                CFG_INTERVAL:  interval   = val[IV_W-1:0];
                CFG_FULLSCALE: full_scale = val[FS_W-1:0];
                default: ;
            endcase
        endfunction

        // Clamp to the limits and scale to 0..255; zero for a crossed or empty range
        function logic [LEVEL_W-1:0] scaled_level(logic [S_BITS-1:0] smp);
            logic [S_BITS-1:0] c;
            int unsigned       q;
            if (high_lim <= low_lim)
                return '0;
            c = smp;
            if (c < low_lim)
                c = low_lim;
            if (c > high_lim)
                c = high_lim;
            q = ((int'(c) - int'(low_lim)) * 255) / (int'(high_lim) - int'(low_lim));
            return q[LEVEL_W-1:0];
        endfunction

        // Smoothed update behind the deadzone and interval gates
        function bit smooth_level(logic [S_BITS-1:0] smp, logic [TIME_W-1:0] stamp);
            logic [S_BITS-1:0] diff;
            logic [TIME_W-1:0] elapsed;
            int unsigned       acc;
            if (high_lim <= low_lim)
            begin
                mode = MODE_UNKNOWN;
                return 1'b0;
            end
            diff = (smp >= last_chg) ? smp - last_chg : last_chg - smp;
            if (diff < deadzone)
                return 1'b0;
            last_chg = smp;
            elapsed = stamp - last_upd;
            if (elapsed < TIME_W'(interval))
                return 1'b0;
            last_upd = stamp;
            acc = (int'(level) * 3 + int'(scaled_level(smp))) / 4;
            level = acc[LEVEL_W-1:0];
            return 1'b1;
        endfunction

        // Advance the mode machine by one item and queue the status it yields
        function void take_sample(sensor_item_t it);
            status_t           st;
            bit                upd;
            logic [S_BITS-1:0] smp;
            upd = 1'b0;
            smp = it.sample_mv;
            if (smp > full_scale)
                mode = MODE_UNKNOWN;
            case (mode)
                MODE_UNCAL:
                    if (it.pressed)
                        mode = MODE_NEED_MIN;
                MODE_NEED_MIN:
                    if (it.pressed)
                    begin
                        low_lim = smp;
                        mode = MODE_NEED_MAX;
                    end
                MODE_NEED_MAX:
                    if (it.pressed)
                    begin
                        high_lim = smp;
                        mode = (low_lim >= high_lim) ? MODE_UNKNOWN : MODE_SUCCESS;
                    end
                MODE_SUCCESS:
                begin
                    if (it.done)
                    begin
                        level = scaled_level(smp);
                        upd = 1'b1;
                        mode = MODE_REGULAR;
                    end
                    if (it.latched)
                        mode = MODE_FORCE;
                end
                MODE_REGULAR:
                begin
                    if (high_lim <= low_lim)
                        mode = MODE_UNKNOWN;
                    else if (smp < low_lim)
                    begin
                        lowest = smp;
                        mode = MODE_BELOW;
                    end
                    else if (smp > high_lim)
                    begin
                        highest = smp;
                        mode = MODE_ABOVE;
                    end
                    if (it.latched)
                        mode = MODE_FORCE;
                    // update still runs on the step that leaves regular mode
                    if (smooth_level(smp, it.stamp_ms))
                        upd = 1'b1;
                end
                MODE_ABOVE:
                begin
                    if (highest < smp)
                        highest = smp;
                    if (it.latched)
                    begin
                        high_lim = highest;
                        highest = '0;
                        mode = MODE_RESET_DONE;
                    end
                end
                MODE_BELOW:
                begin
                    if (lowest > smp)
                        lowest = smp;
                    if (it.latched)
                    begin
                        low_lim = lowest;
                        lowest = '0;
                        mode = MODE_RESET_DONE;
                    end
                end
                MODE_UNKNOWN:
                    if (it.latched)
                        mode = MODE_FORCE;
                MODE_RESET_DONE:
                begin
                    if (low_lim > high_lim)
                        mode = MODE_FORCE;
                    if (it.done)
                        mode = MODE_SUCCESS;
                end
                MODE_FORCE:
                    if (it.done)
                    begin
                        low_lim = '0;
                        high_lim = '0;
                        mode = MODE_UNCAL;
                    end
                default: ;
            endcase
            st.mode = mode;
            st.level = level;
            st.updated = upd;
            status_q.push_back(st);
        endfunction

        // Compare one returned status with the oldest prediction
        function void check_result(logic [OUT_W-1:0] data);
            status_t st;
            if (status_q.size() == 0)
            begin
                $error("unexpected result item 0x%0h", data);
                errors++;
                return;
            end
            st = status_q.pop_front();
            if (data[MODE_W-1:0] !== st.mode)
            begin
                $error("mode: expected %0d, got %0d", st.mode, data[MODE_W-1:0]);
                errors++;
            end
            if (data[MODE_W +: LEVEL_W] !== st.level)
            begin
                $error("brightness_level: expected %0d, got %0d", st.level,
                       data[MODE_W +: LEVEL_W]);
                errors++;
            end
            if (data[MODE_W+LEVEL_W] !== st.updated)
            begin
                $error("level_updated: expected %0d, got %0d", st.updated,
                       data[MODE_W+LEVEL_W]);
                errors++;
            end
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    calib_scoreboard sb;
    bit              src_gaps;
    bit              snk_gaps;
    bit              hold_off_req;
    logic [31:0]     clock_ms;

    light_sensor_calibration_monitor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input sensor_item_t it);
        int gap;
        gap = src_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        // s_tdata: sample_mv, now_ms, button_pressed, button_latched, pattern_done
        s_tdata <= S_W'({it.done, it.latched, it.pressed, it.stamp_ms, it.sample_mv});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.take_sample(it);
    endtask

    task automatic send(input int smp, input logic [31:0] stamp, input bit p,
                        input bit l, input bit d);
        sensor_item_t it;
        it.sample_mv = S_BITS'(smp);
        it.stamp_ms = stamp;
        it.pressed = p;
        it.latched = l;
        it.done = d;
        send_item(it);
    endtask

    // Wait until every predicted status has come back, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Write all three registers in consecutive cycles with the enable held high
    task automatic write_regs(input int dz, input int iv, input int fs);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_DEADZONE;
        cfg_wdata <= CFG_DATA_W'(dz);
        @(posedge clk);
        sb.write_reg(CFG_DEADZONE, CFG_DATA_W'(dz));
        cfg_addr <= CFG_INTERVAL;
        cfg_wdata <= CFG_DATA_W'(iv);
        @(posedge clk);
        sb.write_reg(CFG_INTERVAL, CFG_DATA_W'(iv));
        cfg_addr <= CFG_FULLSCALE;
        cfg_wdata <= CFG_DATA_W'(fs);
        @(posedge clk);
        sb.write_reg(CFG_FULLSCALE, CFG_DATA_W'(fs));
        cfg_we <= 1'b0;
    endtask

    // Random items shaped by the predicted mode so calibration gets through
    task automatic run_phase(input int dz, input int iv, input int fs, input int n,
                             input bit gaps, input bit hold);
        sensor_item_t it;
        int           cap;
        int           lo;
        int           hi;
        int           pick;
        int           p_pct;
        int           l_pct;
        int           d_pct;
        write_regs(dz, iv, fs);
        src_gaps = gaps;
        snk_gaps = gaps;
        for (int k = 0; k < n; k++)
        begin
            if (hold && k == n / 3)
                hold_off_req = 1'b1;
            cap = int'(sb.full_scale);
            lo = int'(sb.low_lim);
            hi = int'(sb.high_lim);
            pick = $urandom_range(0, 99);
            clock_ms = (pick < 3) ? $urandom() : clock_ms + $urandom_range(0, 60);
            p_pct = 5;
            l_pct = 5;
            d_pct = 10;
            case (sb.mode)
                MODE_UNCAL:
                begin
                    it.sample_mv = S_BITS'($urandom_range(0, cap));
                    p_pct = 40;
                end
                MODE_NEED_MIN:
                begin
                    it.sample_mv = S_BITS'($urandom_range(0, cap / 3));
                    p_pct = 40;
                end
                MODE_NEED_MAX:
                begin
                    it.sample_mv = S_BITS'(($urandom_range(0, 9) == 0)
                                           ? $urandom_range(0, cap)
                                           : $urandom_range(cap / 2, cap));
                    p_pct = 40;
                end
                MODE_SUCCESS, MODE_REGULAR:
                begin
                    lo = (lo > 80) ? lo - 80 : 0;
                    hi = (hi + 80 < cap) ? hi + 80 : cap;
                    it.sample_mv = S_BITS'($urandom_range(lo, hi));
                    l_pct = (sb.mode == MODE_REGULAR) ? 2 : 5;
                    d_pct = (sb.mode == MODE_SUCCESS) ? 35 : 10;
                end
                MODE_ABOVE:
                begin
                    it.sample_mv = S_BITS'($urandom_range(hi, cap));
                    l_pct = 30;
                end
                MODE_BELOW:
                begin
                    it.sample_mv = S_BITS'($urandom_range(0, lo));
                    l_pct = 30;
                end
                MODE_UNKNOWN:
                begin
                    it.sample_mv = S_BITS'($urandom_range(0, cap));
                    l_pct = 30;
                end
                default:
                begin
                    it.sample_mv = S_BITS'($urandom_range(0, cap));
                    d_pct = 35;
                end
            endcase
            it.stamp_ms = clock_ms;
            it.pressed = ($urandom_range(0, 99) < p_pct);
            it.latched = ($urandom_range(0, 99) < l_pct);
            it.done = ($urandom_range(0, 99) < d_pct);
            // noise: any sample, any events
            if (pick >= 92)
            begin
                it.sample_mv = S_BITS'($urandom_range(0, (1 << S_BITS) - 1));
                it.pressed = ($urandom_range(0, 1) != 0);
                it.latched = ($urandom_range(0, 1) != 0);
                it.done = ($urandom_range(0, 1) != 0);
            end
            send_item(it);
        end
        drain();
    endtask

    // Check every returned item
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Accept results after a random stall, once with a long hold-off
    initial
    begin : result_sink
        int stall;
        bit hold_taken;
        hold_taken = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = snk_gaps ? $urandom_range(0, 3) : 0;
            if (hold_off_req && !hold_taken)
            begin
                stall = 400;
                hold_taken = 1'b1;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        sb = new();
        src_gaps = 1'b1;
        snk_gaps = 1'b1;
        hold_off_req = 1'b0;
        clock_ms = 32'd10000;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_addr <= CFG_DEADZONE;
        cfg_wdata <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk with reset register values
        send(0, 32'd0, 0, 0, 0);
        // over full scale with a latch goes straight to forced recalibration
        send(3301, 32'hFFFF_FFFF, 0, 1, 0);
        send(100, 32'd10, 0, 0, 1);
        send(100, 32'd20, 1, 0, 0);
        send(400, 32'd30, 1, 0, 0);
        // high limit below low limit ends in unknown
        send(300, 32'd40, 1, 0, 0);
        send(300, 32'd50, 0, 1, 0);
        send(300, 32'd60, 0, 0, 1);
        send(200, 32'd70, 1, 0, 0);
        send(400, 32'd80, 1, 0, 0);
        send(2400, 32'd90, 1, 0, 0);
        // success with pattern done and latch together
        send(1400, 32'd100, 0, 1, 1);
        send(1400, 32'd110, 0, 0, 1);
        send(10, 32'd120, 1, 0, 0);
        send(400, 32'd130, 1, 0, 0);
        send(2400, 32'd140, 1, 0, 0);
        send(1400, 32'd1000, 0, 0, 1);
        send(1500, 32'd1040, 0, 0, 0);
        // leaving regular for below still updates the level
        send(100, 32'd1100, 1, 0, 0);
        send(50, 32'd1110, 0, 0, 0);
        send(80, 32'd1120, 0, 1, 0);
        send(80, 32'd1130, 0, 0, 1);
        send(2400, 32'd1140, 0, 0, 1);
        // elapsed time wraps past zero
        send(3000, 32'd5, 0, 0, 0);
        send(3300, 32'd15, 0, 1, 0);
        send(4095, 32'd25, 0, 1, 1);
        drain();

        run_phase(0, 0, 4095, 200, 1'b1, 1'b1);
        run_phase(4095, 65535, 4095, 100, 1'b0, 1'b0);
        run_phase(12, 5, 3000, 200, 1'b1, 1'b0);
        run_phase(30, 30, 3300, 150, 1'b1, 1'b0);
        run_phase(0, 0, 0, 40, 1'b1, 1'b0);
        run_phase(60, 100, 3900, 135, 1'b0, 1'b0);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("light_sensor_calibration_monitor test passed");
        else
            $display("light_sensor_calibration_monitor test failed");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin : watchdog
        #5000000;
        $display("light_sensor_calibration_monitor test failed");
        $finish;
    end

endmodule
